FILE: rtl/core/jog_target_slew_limiter_defines.svh
// Assertion macros for the jog target slew limiter.
// Included by RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef JOG_TARGET_SLEW_LIMITER_DEFINES_SVH
`define JOG_TARGET_SLEW_LIMITER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JTSL_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define JTSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/jtsl_pkg.sv
// Shared types and constants of the jog target slew limiter.
// Used by every module in rtl/core; depends on nothing.
package jtsl_pkg;

    localparam int DEFAULT_VEL_BITS = 16;

    localparam int STEP_W  = 10;
    localparam int LIMIT_W = 13;
    localparam int SLEW_W  = 10;
    localparam int CMD_W   = 15;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Opcodes of an input transaction.
    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_LIN_UP    = 3'd1;
    localparam logic [OP_W-1:0] OP_LIN_DOWN  = 3'd2;
    localparam logic [OP_W-1:0] OP_ANG_UP    = 3'd3;
    localparam logic [OP_W-1:0] OP_ANG_DOWN  = 3'd4;
    localparam logic [OP_W-1:0] OP_LIN_CLEAR = 3'd5;
    localparam logic [OP_W-1:0] OP_ANG_CLEAR = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_SLEW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_SLEW  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]  RST_LIN_STEP  = 10'd100;
    localparam logic [LIMIT_W-1:0] RST_LIN_LIMIT = 13'd2000;
    localparam logic [STEP_W-1:0]  RST_ANG_STEP  = 10'd157;
    localparam logic [LIMIT_W-1:0] RST_ANG_LIMIT = 13'd3140;
    localparam logic [SLEW_W-1:0]  RST_LIN_SLEW  = 10'd50;
    localparam logic [SLEW_W-1:0]  RST_ANG_SLEW  = 10'd100;

    typedef struct packed {
        logic [STEP_W-1:0]  lin_step;
        logic [LIMIT_W-1:0] lin_limit;
        logic [STEP_W-1:0]  ang_step;
        logic [LIMIT_W-1:0] ang_limit;
        logic [SLEW_W-1:0]  lin_slew;
        logic [SLEW_W-1:0]  ang_slew;
    } jtsl_cfg_t;

    // Target update request for one axis.
    typedef struct packed {
        logic up;
        logic down;
        logic clear;
    } jtsl_step_cmd_t;

endpackage

FILE: rtl/core/jtsl_cfg.sv
// Configuration register bank of the jog target slew limiter.
// Depends on jtsl_pkg for register indexes, widths and reset values.
module jtsl_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [jtsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jtsl_pkg::CFG_DATA_W-1:0]     cfg_data,
    output jtsl_pkg::jtsl_cfg_t                 cfg
);

    jtsl_pkg::jtsl_cfg_t cfg_reg;
    jtsl_pkg::jtsl_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                jtsl_pkg::CFG_LIN_STEP:  cfg_next.lin_step  = cfg_data[jtsl_pkg::STEP_W-1:0];
                jtsl_pkg::CFG_LIN_LIMIT: cfg_next.lin_limit = cfg_data[jtsl_pkg::LIMIT_W-1:0];
                jtsl_pkg::CFG_ANG_STEP:  cfg_next.ang_step  = cfg_data[jtsl_pkg::STEP_W-1:0];
                jtsl_pkg::CFG_ANG_LIMIT: cfg_next.ang_limit = cfg_data[jtsl_pkg::LIMIT_W-1:0];
                jtsl_pkg::CFG_LIN_SLEW:  cfg_next.lin_slew  = cfg_data[jtsl_pkg::SLEW_W-1:0];
                jtsl_pkg::CFG_ANG_SLEW:  cfg_next.ang_slew  = cfg_data[jtsl_pkg::SLEW_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lin_step  <= jtsl_pkg::RST_LIN_STEP;
            cfg_reg.lin_limit <= jtsl_pkg::RST_LIN_LIMIT;
            cfg_reg.ang_step  <= jtsl_pkg::RST_ANG_STEP;
            cfg_reg.ang_limit <= jtsl_pkg::RST_ANG_LIMIT;
            cfg_reg.lin_slew  <= jtsl_pkg::RST_LIN_SLEW;
            cfg_reg.ang_slew  <= jtsl_pkg::RST_ANG_SLEW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/jtsl_target.sv
// Jog target register of one axis with limited, saturating step updates.
// Depends on jtsl_pkg for the step command struct and field widths.
module jtsl_target #(
    parameter int VEL_BITS = jtsl_pkg::DEFAULT_VEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jtsl_pkg::jtsl_step_cmd_t           cmd,
    input  logic [jtsl_pkg::STEP_W-1:0]        step,
    input  logic [jtsl_pkg::LIMIT_W-1:0]       limit,
    output logic signed [VEL_BITS-1:0]         target
);

    logic signed [VEL_BITS-1:0] target_reg;
    logic signed [VEL_BITS-1:0] target_next;
    logic signed [VEL_BITS:0]   tgt_x;
    logic signed [VEL_BITS:0]   lim_x;
    logic signed [VEL_BITS:0]   step_x;

    // Clamp a one-bit-wider value back into the signed target range.
    function automatic logic signed [VEL_BITS-1:0] sat_w(input logic signed [VEL_BITS:0] v);
        logic signed [VEL_BITS-1:0] r;
        if (v[VEL_BITS] != v[VEL_BITS-1])
            r = v[VEL_BITS] ? {1'b1, {(VEL_BITS-1){1'b0}}} : {1'b0, {(VEL_BITS-1){1'b1}}};
        else
            r = v[VEL_BITS-1:0];
        return r;
    endfunction

    assign tgt_x  = {target_reg[VEL_BITS-1], target_reg};
    assign lim_x  = $signed({{(VEL_BITS+1-jtsl_pkg::LIMIT_W){1'b0}}, limit});
    assign step_x = $signed({{(VEL_BITS+1-jtsl_pkg::STEP_W){1'b0}}, step});

    // A step is taken only while the target still lies inside the limit,
    // so the target may end up one step beyond it.
    always_comb
    begin
        target_next = target_reg;
        if (cmd.clear)
            target_next = '0;
        else if (cmd.up && (tgt_x <= lim_x))
            target_next = sat_w(tgt_x + step_x);
        else if (cmd.down && (tgt_x >= -lim_x))
            target_next = sat_w(tgt_x - step_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_reg <= '0;
        else
            target_reg <= target_next;
    end

    assign target = target_reg;

endmodule

FILE: rtl/core/jtsl_slew.sv
// Commanded velocity register of one axis that moves toward its target at a bounded rate.
// Depends on jtsl_pkg for the slew field width.
module jtsl_slew #(
    parameter int VEL_BITS = jtsl_pkg::DEFAULT_VEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tick,
    input  logic signed [VEL_BITS-1:0]         target,
    input  logic [jtsl_pkg::SLEW_W-1:0]        slew,
    output logic signed [VEL_BITS-1:0]         now,
    output logic signed [VEL_BITS-1:0]         now_next
);

    logic signed [VEL_BITS-1:0] now_reg;
    logic signed [VEL_BITS:0]   now_x;
    logic signed [VEL_BITS:0]   diff;
    logic [VEL_BITS:0]          mag;
    logic signed [VEL_BITS:0]   slew_x;
    logic signed [VEL_BITS:0]   moved;

    function automatic logic signed [VEL_BITS-1:0] sat_w(input logic signed [VEL_BITS:0] v);
        logic signed [VEL_BITS-1:0] r;
        if (v[VEL_BITS] != v[VEL_BITS-1])
            r = v[VEL_BITS] ? {1'b1, {(VEL_BITS-1){1'b0}}} : {1'b0, {(VEL_BITS-1){1'b1}}};
        else
            r = v[VEL_BITS-1:0];
        return r;
    endfunction

    assign now_x  = {now_reg[VEL_BITS-1], now_reg};
    assign diff   = {target[VEL_BITS-1], target} - now_x;
    assign mag    = diff[VEL_BITS] ? $unsigned(-diff) : $unsigned(diff);
    assign slew_x = $signed({{(VEL_BITS+1-jtsl_pkg::SLEW_W){1'b0}}, slew});
    assign moved  = diff[VEL_BITS] ? (now_x - slew_x) : (now_x + slew_x);

    // Within reach of the target the command snaps onto it.
    assign now_next = (mag > $unsigned(slew_x)) ? sat_w(moved) : target;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            now_reg <= '0;
        else if (tick)
            now_reg <= now_next;
    end

    assign now = now_reg;

endmodule

FILE: rtl/core/jog_target_slew_limiter.sv
// Top level of the jog target slew limiter: input register, target and slew units,
// result register. Depends on jtsl_pkg, jtsl_cfg, jtsl_target, jtsl_slew and the defines header.
`include "jog_target_slew_limiter_defines.svh"

// The block takes one transaction per clock while it does not stall its input, and answers
// a tick through the input register and then the result register. Each event
// passes through add, compare and select in the target unit of its
// axis, and a tick through the same in each slew unit, so the sustained rate is
// one transaction per cycle whenever the result side keeps taking results. Step and
// reset events change a target and never produce a result. A tick moves each command
// toward its target by at most the slew value and produces a result while either
// command is nonzero, plus one final zero pair once motion has stopped. The result
// register frees the input side: while a result waits on result_stall, the block still
// works on events that produce no result, and holds off any tick that reaches the input
// register while a result is waiting, even a tick that would itself produce nothing.
// Configuration writes are meant for idle periods only.
module jog_target_slew_limiter #(
    parameter int VEL_BITS = jtsl_pkg::DEFAULT_VEL_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [jtsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jtsl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [jtsl_pkg::OP_W-1:0]           opcode,
    input  logic                                assisted_mode,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [jtsl_pkg::CMD_W-1:0]   linear_cmd,
    output logic signed [jtsl_pkg::CMD_W-1:0]   angular_cmd,
    output logic                                route
);

    jtsl_pkg::jtsl_cfg_t       cfg;
    jtsl_pkg::jtsl_step_cmd_t  lin_cmd;
    jtsl_pkg::jtsl_step_cmd_t  ang_cmd;

    // Input register.
    logic                       hold_valid_reg;
    logic                       hold_valid_next;
    logic [jtsl_pkg::OP_W-1:0]  op_reg;
    logic                       assist_reg;

    // Result register.
    logic                                result_valid_reg;
    logic                                result_valid_next;
    logic signed [jtsl_pkg::CMD_W-1:0]   lin_out_reg;
    logic signed [jtsl_pkg::CMD_W-1:0]   ang_out_reg;
    logic                                route_reg;

    logic stop_reported_reg;
    logic stop_reported_next;

    logic signed [VEL_BITS-1:0] lin_target;
    logic signed [VEL_BITS-1:0] ang_target;
    logic signed [VEL_BITS-1:0] lin_now;
    logic signed [VEL_BITS-1:0] ang_now;
    logic signed [VEL_BITS-1:0] lin_next;
    logic signed [VEL_BITS-1:0] ang_next;

    logic is_tick;
    logic advance;
    logic take;
    logic tick;
    logic moving;
    logic emit;
    logic accept;

    // Only a tick can produce a result, so only a tick has to wait for the result
    // register to drain.
    assign is_tick    = (op_reg == jtsl_pkg::OP_TICK);
    assign advance    = !is_tick || !result_valid_reg || !result_stall;
    assign take       = hold_valid_reg && advance;
    assign tick       = take && is_tick;
    assign item_stall = hold_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    jtsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Decode the held event into per-axis target requests.
    always_comb
    begin
        lin_cmd = '0;
        ang_cmd = '0;
        if (take)
        begin
            unique case (op_reg)
                jtsl_pkg::OP_LIN_UP:    lin_cmd.up    = 1'b1;
                jtsl_pkg::OP_LIN_DOWN:  lin_cmd.down  = 1'b1;
                jtsl_pkg::OP_ANG_UP:    ang_cmd.up    = 1'b1;
                jtsl_pkg::OP_ANG_DOWN:  ang_cmd.down  = 1'b1;
                jtsl_pkg::OP_LIN_CLEAR: lin_cmd.clear = 1'b1;
                jtsl_pkg::OP_ANG_CLEAR: ang_cmd.clear = 1'b1;
                default:
                begin
                    lin_cmd = '0;
                    ang_cmd = '0;
                end
            endcase
        end
    end

    jtsl_target #(.VEL_BITS(VEL_BITS)) u_lin_target (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (lin_cmd),
        .step   (cfg.lin_step),
        .limit  (cfg.lin_limit),
        .target (lin_target)
    );

    jtsl_target #(.VEL_BITS(VEL_BITS)) u_ang_target (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ang_cmd),
        .step   (cfg.ang_step),
        .limit  (cfg.ang_limit),
        .target (ang_target)
    );

    jtsl_slew #(.VEL_BITS(VEL_BITS)) u_lin_slew (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .target   (lin_target),
        .slew     (cfg.lin_slew),
        .now      (lin_now),
        .now_next (lin_next)
    );

    jtsl_slew #(.VEL_BITS(VEL_BITS)) u_ang_slew (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .target   (ang_target),
        .slew     (cfg.ang_slew),
        .now      (ang_now),
        .now_next (ang_next)
    );

    // A tick reports while anything moves, and once more with the zero pair when
    // both commands have come to rest.
    assign moving = (lin_next != '0) || (ang_next != '0);
    assign emit   = tick && (moving || !stop_reported_reg);

    always_comb
    begin
        stop_reported_next = stop_reported_reg;
        if (tick)
            stop_reported_next = !moving;
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (take)
            hold_valid_next = 1'b0;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (emit)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
            stop_reported_reg <= 1'b1;
        end
        else
        begin
            hold_valid_reg    <= hold_valid_next;
            result_valid_reg  <= result_valid_next;
            stop_reported_reg <= stop_reported_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            assist_reg <= assisted_mode;
        end
        if (emit)
        begin
            lin_out_reg <= lin_next[jtsl_pkg::CMD_W-1:0];
            ang_out_reg <= ang_next[jtsl_pkg::CMD_W-1:0];
            route_reg   <= assist_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign linear_cmd   = lin_out_reg;
    assign angular_cmd  = ang_out_reg;
    assign route        = route_reg;

    // The stop flag is only ever set while both commands rest at zero.
    `JTSL_ASSERT_HOLDS(a_stop_means_rest, stop_reported_reg,
        (lin_now == '0) && (ang_now == '0), "stop flag set while a command is nonzero")

    // A new result must never overwrite one that is still waiting.
    `JTSL_ASSERT_HOLDS(a_no_overwrite, result_valid_reg && result_stall, !emit,
        "result produced while the result register is stalled")

    // Emitting the zero pair marks the axis pair as stopped.
    `JTSL_ASSERT_NEXT(a_zero_pair_sets_stop, emit && !moving, stop_reported_reg,
        "zero pair sent without setting the stop flag")

    // A held event that cannot proceed stays in the input register unchanged.
    `JTSL_ASSERT_NEXT(a_hold_kept, item_stall, hold_valid_reg && (op_reg == $past(op_reg)),
        "stalled event lost from the input register")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for jog_target_slew_limiter: an in-bench model of the jog targets
// and slewed commands predicts every command pair. Depends on jtsl_pkg and the RTL only.
`timescale 1ns / 100ps

localparam int VEL_W   = jtsl_pkg::DEFAULT_VEL_BITS;
localparam int VEL_MAX = (1 << (VEL_W - 1)) - 1;
localparam int VEL_MIN = -(1 << (VEL_W - 1));

typedef logic signed [VEL_W-1:0] vel_t;

// One command pair as it leaves the block.
typedef struct packed {
    logic signed [jtsl_pkg::CMD_W-1:0] linear_cmd;
    logic signed [jtsl_pkg::CMD_W-1:0] angular_cmd;
    logic                              route;
} cmd_pair_t;

// Tracks the jog targets and commands, and holds the command pairs still owed by the block.
class slew_scoreboard;
    logic [jtsl_pkg::STEP_W-1:0]  lin_step, ang_step;
    logic [jtsl_pkg::LIMIT_W-1:0] lin_limit, ang_limit;
    logic [jtsl_pkg::SLEW_W-1:0]  lin_slew, ang_slew;
    vel_t      lin_target, ang_target, lin_now, ang_now;
    bit        zero_pair_sent;
    cmd_pair_t owed_cmds[$];
    int        errors;

    function new();
        lin_step       = jtsl_pkg::RST_LIN_STEP;
        lin_limit      = jtsl_pkg::RST_LIN_LIMIT;
        ang_step       = jtsl_pkg::RST_ANG_STEP;
        ang_limit      = jtsl_pkg::RST_ANG_LIMIT;
        lin_slew       = jtsl_pkg::RST_LIN_SLEW;
        ang_slew       = jtsl_pkg::RST_ANG_SLEW;
        lin_target     = '0;
        ang_target     = '0;
        lin_now        = '0;
        ang_now        = '0;
        zero_pair_sent = 1'b1;
        errors         = 0;
    endfunction

    function int owed();
        return owed_cmds.size();
    endfunction

    function void set_reg(logic [jtsl_pkg::CFG_IDX_W-1:0] idx,
                          logic [jtsl_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            jtsl_pkg::CFG_LIN_STEP:  lin_step  = data[jtsl_pkg::STEP_W-1:0];
            jtsl_pkg::CFG_LIN_LIMIT: lin_limit = data[jtsl_pkg::LIMIT_W-1:0];
            jtsl_pkg::CFG_ANG_STEP:  ang_step  = data[jtsl_pkg::STEP_W-1:0];
            jtsl_pkg::CFG_ANG_LIMIT: ang_limit = data[jtsl_pkg::LIMIT_W-1:0];
            jtsl_pkg::CFG_LIN_SLEW:  lin_slew  = data[jtsl_pkg::SLEW_W-1:0];
            jtsl_pkg::CFG_ANG_SLEW:  ang_slew  = data[jtsl_pkg::SLEW_W-1:0];
            default: ;
        endcase
    endfunction

    function vel_t clamp_vel(int v);
        if (v > VEL_MAX) return vel_t'(VEL_MAX);
        if (v < VEL_MIN) return vel_t'(VEL_MIN);
        return vel_t'(v);
    endfunction

    // A step is taken only while the target still lies inside the limit.
    function vel_t raise(vel_t t, int amount, int lim);
        if (int'(t) <= lim) return clamp_vel(int'(t) + amount);
        return t;
    endfunction

    function vel_t lower(vel_t t, int amount, int lim);
        if (int'(t) >= -lim) return clamp_vel(int'(t) - amount);
        return t;
    endfunction

    function vel_t approach(vel_t now, vel_t target, int slew);
        int diff;
        int mag;
        diff = int'(target) - int'(now);
        mag  = (diff < 0) ? -diff : diff;
        if (mag > slew)
            return clamp_vel((diff > 0) ? int'(now) + slew : int'(now) - slew);
        return target;
    endfunction

    // Called for every accepted input transaction.
    function void accept_event(logic [jtsl_pkg::OP_W-1:0] op, logic assisted);
        cmd_pair_t pair;
        case (op)
            jtsl_pkg::OP_LIN_UP:    lin_target = raise(lin_target, int'(lin_step), int'(lin_limit));
            jtsl_pkg::OP_LIN_DOWN:  lin_target = lower(lin_target, int'(lin_step), int'(lin_limit));
            jtsl_pkg::OP_ANG_UP:    ang_target = raise(ang_target, int'(ang_step), int'(ang_limit));
            jtsl_pkg::OP_ANG_DOWN:  ang_target = lower(ang_target, int'(ang_step), int'(ang_limit));
            jtsl_pkg::OP_LIN_CLEAR: lin_target = '0;
            jtsl_pkg::OP_ANG_CLEAR: ang_target = '0;
            jtsl_pkg::OP_TICK:
            begin
                lin_now = approach(lin_now, lin_target, int'(lin_slew));
                ang_now = approach(ang_now, ang_target, int'(ang_slew));
                if (lin_now != 0 || ang_now != 0)
                    zero_pair_sent = 1'b0;
                else if (!zero_pair_sent)
                    zero_pair_sent = 1'b1;
                else
                    return;
                pair.linear_cmd  = lin_now[jtsl_pkg::CMD_W-1:0];
                pair.angular_cmd = ang_now[jtsl_pkg::CMD_W-1:0];
                pair.route       = assisted;
                owed_cmds.push_back(pair);
            end
            default: ;
        endcase
    endfunction

    // Called for every accepted result transaction.
    function void check_command(logic signed [jtsl_pkg::CMD_W-1:0] lin,
                                logic signed [jtsl_pkg::CMD_W-1:0] ang, logic rt);
        cmd_pair_t want;
        if (owed_cmds.size() == 0)
        begin
            $error("unexpected command pair: linear_cmd %0d angular_cmd %0d route %0d",
                   lin, ang, rt);
            errors++;
            return;
        end
        want = owed_cmds.pop_front();
        if (lin !== want.linear_cmd)
        begin
            $error("linear_cmd: expected %0d, actual %0d", want.linear_cmd, lin);
            errors++;
        end
        if (ang !== want.angular_cmd)
        begin
            $error("angular_cmd: expected %0d, actual %0d", want.angular_cmd, ang);
            errors++;
        end
        if (rt !== want.route)
        begin
            $error("route: expected %0d, actual %0d", want.route, rt);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int OP_BITS   = jtsl_pkg::OP_W;
    localparam int DATA_BITS = jtsl_pkg::CFG_DATA_W;

    // Opcode 7 has no meaning; the block must ignore it.
    localparam logic [jtsl_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    // The block answers a tick through its input and result registers; a few spare clocks cover
    // events that are still in flight when the last command pair has come back.
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 16;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [jtsl_pkg::CFG_IDX_W-1:0]        cfg_index = jtsl_pkg::CFG_LIN_STEP;
    logic [jtsl_pkg::CFG_DATA_W-1:0]       cfg_data = '0;
    logic                                  item_valid = 1'b0;
    logic                                  item_stall;
    logic [jtsl_pkg::OP_W-1:0]             opcode = jtsl_pkg::OP_TICK;
    logic                                  assisted_mode = 1'b0;
    logic                                  result_valid;
    logic                                  result_stall = 1'b0;
    logic signed [jtsl_pkg::CMD_W-1:0]     linear_cmd;
    logic signed [jtsl_pkg::CMD_W-1:0]     angular_cmd;
    logic                                  route;

    // Flags shared between the stimulus process and the result-side process, and the run-length count.
    bit quiet = 1'b0;          // no idling on either side while set
    bit hold_request = 1'b0;   // asks the result side for one long hold-off
    int cycles = 0;

    slew_scoreboard sb = new();

    jog_target_slew_limiter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .opcode        (opcode),
        .assisted_mode (assisted_mode),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .linear_cmd    (linear_cmd),
        .angular_cmd   (angular_cmd),
        .route         (route)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Every signal is updated with nonblocking assignments at the rising edge, so
    // sampling here always sees the values from just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_command(linear_cmd, angular_cmd, route);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls about one cycle in six, none while the quiet stretch
    // runs, and one long hold-off on request so that the result register stays full
    // and the block has to push back on ticks.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Offers one transaction and returns at the edge where it is accepted. The model
    // is updated at that point, in acceptance order.
    task automatic send_event(input logic [jtsl_pkg::OP_W-1:0] op, input logic assisted);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        opcode        <= op;
        assisted_mode <= assisted;
        item_valid    <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sb.accept_event(op, assisted);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_event(jtsl_pkg::OP_TICK, 1'($urandom_range(1)));
    endtask

    // Stops offering, waits for every owed command pair, then lets in-flight events settle.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Rewrites all six registers while the block is idle.
    task automatic load_settings(input int lstep, input int llim, input int astep,
                                 input int alim, input int lslew, input int aslew);
        logic [jtsl_pkg::CFG_IDX_W-1:0]  idx [6];
        logic [jtsl_pkg::CFG_DATA_W-1:0] val [6];
        idx = '{jtsl_pkg::CFG_LIN_STEP, jtsl_pkg::CFG_LIN_LIMIT, jtsl_pkg::CFG_ANG_STEP,
                jtsl_pkg::CFG_ANG_LIMIT, jtsl_pkg::CFG_LIN_SLEW, jtsl_pkg::CFG_ANG_SLEW};
        val = '{DATA_BITS'(lstep), DATA_BITS'(llim), DATA_BITS'(astep),
                DATA_BITS'(alim), DATA_BITS'(lslew), DATA_BITS'(aslew)};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_random_settings();
        load_settings($urandom_range(0, 1000), $urandom_range(0, 8000),
                      $urandom_range(0, 1000), $urandom_range(0, 8000),
                      $urandom_range(0, 1000), $urandom_range(0, 1000));
    endtask

    // Random traffic. Most of it is jog-like: a burst of steps on one axis followed by
    // a run of ticks so the commands chase the new target; some of it clears a target
    // and ticks down to the final zero pair; the rest is raw noise including the
    // unused opcode. Ignored transactions do not count toward the total.
    task automatic run_random(input int total);
        int sent;
        int pick;
        int burst;
        logic [jtsl_pkg::OP_W-1:0] op;
        sent = 0;
        while (sent < total)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                op    = OP_BITS'($urandom_range(jtsl_pkg::OP_LIN_UP, jtsl_pkg::OP_ANG_DOWN));
                burst = $urandom_range(1, 8);
                repeat (burst) send_event(op, 1'($urandom_range(1)));
                if ($urandom_range(3) == 0)
                begin
                    send_event(OP_BITS'($urandom_range(jtsl_pkg::OP_LIN_UP,
                                                       jtsl_pkg::OP_ANG_DOWN)),
                               1'($urandom_range(1)));
                    burst++;
                end
                sent += burst;
                burst = $urandom_range(1, 24);
                send_ticks(burst);
                sent += burst;
            end
            else if (pick < 80)
            begin
                send_event(($urandom_range(1) != 0) ? jtsl_pkg::OP_LIN_CLEAR
                                                    : jtsl_pkg::OP_ANG_CLEAR,
                           1'($urandom_range(1)));
                burst = $urandom_range(1, 30);
                send_ticks(burst);
                sent += burst + 1;
            end
            else
            begin
                op = OP_BITS'($urandom_range(0, 7));
                send_event(op, 1'($urandom_range(1)));
                if (op != OP_UNUSED)
                    sent++;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings. A tick while stopped gives nothing, the unused opcode is
        // ignored, then a little motion on both axes with both routes, and clearing
        // both targets ends in exactly one zero pair.
        send_event(jtsl_pkg::OP_TICK, 1'b0);
        send_event(OP_UNUSED, 1'b1);
        send_event(jtsl_pkg::OP_TICK, 1'b1);
        send_event(jtsl_pkg::OP_ANG_UP, 1'b0);
        send_event(jtsl_pkg::OP_TICK, 1'b1);
        send_event(jtsl_pkg::OP_LIN_DOWN, 1'b1);
        send_ticks(3);
        send_event(jtsl_pkg::OP_ANG_CLEAR, 1'b0);
        send_event(jtsl_pkg::OP_LIN_CLEAR, 1'b1);
        send_ticks(4);

        // A step of 1000 against a limit of one step: the second step overshoots the
        // limit and the third is refused. A zero limit still allows one step down from
        // zero. With zero angular slew the angular command never moves.
        load_settings(1000, 1000, 1000, 0, 1000, 0);
        send_event(jtsl_pkg::OP_LIN_UP, 1'b0);
        send_event(jtsl_pkg::OP_LIN_UP, 1'b1);
        send_event(jtsl_pkg::OP_LIN_UP, 1'b0);
        send_event(jtsl_pkg::OP_ANG_DOWN, 1'b1);
        send_event(jtsl_pkg::OP_ANG_DOWN, 1'b0);
        send_event(jtsl_pkg::OP_ANG_UP, 1'b1);
        send_ticks(3);
        send_event(jtsl_pkg::OP_LIN_CLEAR, 1'b0);
        send_ticks(3);

        // Reset values again, with one long hold-off on the result side while ticks
        // keep coming, so the block fills and stalls its input.
        load_settings(jtsl_pkg::RST_LIN_STEP, jtsl_pkg::RST_LIN_LIMIT,
                      jtsl_pkg::RST_ANG_STEP, jtsl_pkg::RST_ANG_LIMIT,
                      jtsl_pkg::RST_LIN_SLEW, jtsl_pkg::RST_ANG_SLEW);
        repeat (6) send_event(jtsl_pkg::OP_LIN_UP, 1'b0);
        hold_request = 1'b1;
        send_ticks(20);
        run_random(260);

        // Every register at the top of its random range.
        load_settings(1000, 8000, 1000, 8000, 1000, 1000);
        run_random(250);

        // A stretch with no idling on either side.
        quiet = 1'b1;
        load_random_settings();
        run_random(300);
        quiet = 1'b0;

        // Every register at zero: steps leave the targets unchanged, only clears move them,
        // and the commands never move.
        load_settings(0, 0, 0, 0, 0, 0);
        run_random(120);

        // Large steps with a crawling slew give long runs of nonzero pairs.
        load_settings(1000, $urandom_range(0, 8000), 1000, $urandom_range(0, 8000),
                      $urandom_range(1, 3), $urandom_range(1, 3));
        run_random(200);

        load_random_settings();
        run_random(220);
        load_random_settings();
        run_random(220);

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
